// ===== rtl/stu_pkg.sv =====
// Shared types, constants and character helpers for the source tokenizer.
// Used by every module of the tokenizer; depends on nothing else.
package stu_pkg;

  localparam int OffsetBitsDefault = 32;
  localparam int LineBitsDefault   = 24;

  localparam int KwCount    = 8;
  localparam int KwMaxLen   = 13;
  localparam int KwTextBits = 8 * KwMaxLen;

  localparam int TokKindBits  = 5;
  localparam int TokFifoDepth = 4;
  localparam int TokFifoPtrW  = $clog2(TokFifoDepth);

  // Scanner state, one-hot.
  typedef enum logic [5:0] {
    ModeIdle  = 6'b000001,
    ModeIdent = 6'b000010,
    ModeNum   = 6'b000100,
    ModeStr   = 6'b001000,
    ModeEq    = 6'b010000,
    ModeBang  = 6'b100000
  } scan_mode_e;

  // Token kind codes.
  localparam logic [TokKindBits-1:0] TokIllegal = 5'd0;
  localparam logic [TokKindBits-1:0] TokEnd     = 5'd1;
  localparam logic [TokKindBits-1:0] TokIdent   = 5'd2;
  localparam logic [TokKindBits-1:0] TokInt     = 5'd3;
  localparam logic [TokKindBits-1:0] TokString  = 5'd4;
  localparam logic [TokKindBits-1:0] TokAssign  = 5'd5;
  localparam logic [TokKindBits-1:0] TokPlus    = 5'd6;
  localparam logic [TokKindBits-1:0] TokMinus   = 5'd7;
  localparam logic [TokKindBits-1:0] TokSlash   = 5'd8;
  localparam logic [TokKindBits-1:0] TokStar    = 5'd9;
  localparam logic [TokKindBits-1:0] TokBang    = 5'd10;
  localparam logic [TokKindBits-1:0] TokLess    = 5'd11;
  localparam logic [TokKindBits-1:0] TokGreater = 5'd12;
  localparam logic [TokKindBits-1:0] TokLParen  = 5'd13;
  localparam logic [TokKindBits-1:0] TokRParen  = 5'd14;
  localparam logic [TokKindBits-1:0] TokLBrace  = 5'd15;
  localparam logic [TokKindBits-1:0] TokRBrace  = 5'd16;
  localparam logic [TokKindBits-1:0] TokComma   = 5'd17;
  localparam logic [TokKindBits-1:0] TokSemi    = 5'd18;
  localparam logic [TokKindBits-1:0] TokEqEq    = 5'd19;
  localparam logic [TokKindBits-1:0] TokNotEq   = 5'd20;
  localparam logic [TokKindBits-1:0] TokKwFirst = 5'd21;

  // Source characters with special meaning.
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChEqual   = 8'h3d;
  localparam logic [7:0] ChUnder   = 8'h5f;

  // Keyword text, left aligned and zero padded to the longest keyword.
  localparam logic [KwTextBits-1:0] KwText [KwCount] = '{
    {"variable", 40'h0},
    {"procedimiento"},
    {"mientras", 40'h0},
    {"regresa", 48'h0},
    {"si", 88'h0},
    {"si_no", 64'h0},
    {"verdadero", 32'h0},
    {"falso", 64'h0}
  };

  localparam logic [3:0] KwLen [KwCount] = '{
    4'd8, 4'd13, 4'd8, 4'd7, 4'd2, 4'd5, 4'd9, 4'd5
  };

  typedef struct packed {
    logic push0;
    logic push1;
  } tok_push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChUnder);
  endfunction

  function automatic logic [TokKindBits-1:0] single_kind(input logic [7:0] c);
    logic [TokKindBits-1:0] k;
    case (c)
      "+":     k = TokPlus;
      "-":     k = TokMinus;
      "/":     k = TokSlash;
      "*":     k = TokStar;
      "<":     k = TokLess;
      ">":     k = TokGreater;
      "(":     k = TokLParen;
      ")":     k = TokRParen;
      "{":     k = TokLBrace;
      "}":     k = TokRBrace;
      ",":     k = TokComma;
      ";":     k = TokSemi;
      default: k = TokIllegal;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/source_tokenizer_unit.sv =====
// Source tokenizer, top level: scanner plus output token queue.
// Depends on stu_pkg, stu_scanner, stu_tok_fifo.
//
// Takes one source byte (or an end-of-source mark) per cycle while in_stall_o is
// low and returns tokens with kind, starting line, text offset and text length;
// the last token caused by an input carries last_of_run. A byte enters in every
// cycle in which the four-entry token queue has at least two free entries, and
// its tokens can be taken from the output in the next cycle. An input gives
// zero, one or two tokens; since one token leaves per cycle while out_stall_i is
// low, a stream that often yields two tokens per byte runs at that output rate.
module source_tokenizer_unit #(
  parameter int OFFSET_BITS = stu_pkg::OffsetBitsDefault,
  parameter int LINE_BITS   = stu_pkg::LineBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [7:0]                      char_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [stu_pkg::TokKindBits-1:0] token_kind_o,
  output logic [LINE_BITS-1:0]            token_line_o,
  output logic [OFFSET_BITS-1:0]          text_start_o,
  output logic [OFFSET_BITS-1:0]          text_length_o,
  output logic                            last_of_run_o
);

  localparam int TokW = stu_pkg::TokKindBits + LINE_BITS + 2 * OFFSET_BITS + 1;

  stu_pkg::tok_push_t push;
  logic [TokW-1:0]    tok0, tok1, tok_out;
  logic               accept;
  logic               room_lt2;

  assign in_stall_o = room_lt2;
  assign accept     = in_valid_i && !room_lt2;

  stu_scanner #(
    .OffsetBits(OFFSET_BITS),
    .LineBits  (LINE_BITS)
  ) u_scanner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .kind_i  (kind_i),
    .char_i  (char_byte_i),
    .push_o  (push),
    .tok0_o  (tok0),
    .tok1_o  (tok1)
  );

  stu_tok_fifo #(
    .DataWidth(TokW)
  ) u_tok_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .din0_i     (tok0),
    .din1_i     (tok1),
    .room_lt2_o (room_lt2),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .dout_o     (tok_out)
  );

  assign {token_kind_o, token_line_o, text_start_o, text_length_o, last_of_run_o} = tok_out;

endmodule

// ===== rtl/stu_kw_match.sv =====
// Keyword matcher: one prefix-match flag per keyword, updated a byte at a time,
// and the final identifier kind. Depends on stu_pkg.
module stu_kw_match #(
  parameter int OffsetBits = stu_pkg::OffsetBitsDefault
) (
  input  logic [stu_pkg::KwCount-1:0]     hits_in_i,
  input  logic [OffsetBits-1:0]           match_idx_i,
  input  logic [7:0]                      char_i,
  output logic [stu_pkg::KwCount-1:0]     hits_out_o,
  input  logic [stu_pkg::KwCount-1:0]     hits_q_i,
  input  logic [OffsetBits-1:0]           ident_len_i,
  output logic [stu_pkg::TokKindBits-1:0] ident_kind_o
);

  logic [stu_pkg::KwCount-1:0]    keep;
  logic [3:0]                     idx4;
  logic [stu_pkg::KwTextBits-1:0] shifted [stu_pkg::KwCount];

  assign idx4 = match_idx_i[3:0];

  always_comb begin
    for (int k = 0; k < stu_pkg::KwCount; k++) begin
      shifted[k] = stu_pkg::KwText[k] << {idx4, 3'b000};
      keep[k] = (match_idx_i < OffsetBits'(stu_pkg::KwLen[k])) &&
                (shifted[k][stu_pkg::KwTextBits-1 -: 8] == char_i);
    end
  end

  assign hits_out_o = hits_in_i & keep;

  // The highest keyword whose flag survived and whose length fits wins.
  always_comb begin
    ident_kind_o = stu_pkg::TokIdent;
    for (int k = 0; k < stu_pkg::KwCount; k++) begin
      if (hits_q_i[k] && (ident_len_i == OffsetBits'(stu_pkg::KwLen[k]))) begin
        ident_kind_o = stu_pkg::TokKwFirst + stu_pkg::TokKindBits'(k);
      end
    end
  end

endmodule

// ===== rtl/stu_scanner.sv =====
// Scanner state and per-byte token decision: holds the scan mode, offsets and
// line count, and forms up to two tokens per byte. Depends on stu_pkg, stu_kw_match.
module stu_scanner #(
  parameter int OffsetBits = stu_pkg::OffsetBitsDefault,
  parameter int LineBits   = stu_pkg::LineBitsDefault,
  localparam int TokW      = stu_pkg::TokKindBits + LineBits + 2 * OffsetBits + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               kind_i,
  input  logic [7:0]         char_i,
  output stu_pkg::tok_push_t push_o,
  output logic [TokW-1:0]    tok0_o,
  output logic [TokW-1:0]    tok1_o
);

  stu_pkg::scan_mode_e mode_q, mode_d;
  logic [7:0]                  quote_q, quote_d;
  logic [OffsetBits-1:0]       off_q, off_d;
  logic [OffsetBits-1:0]       start_q, start_d;
  logic [LineBits-1:0]         line_q, line_d;
  logic [stu_pkg::KwCount-1:0] hits_q, hits_d;

  logic [OffsetBits-1:0]       cur_len;
  logic [OffsetBits-1:0]       start_plus1;
  logic [stu_pkg::TokKindBits-1:0] ident_kind;

  // Flush of the pending token in the current mode.
  logic                            fl_valid;
  logic [stu_pkg::TokKindBits-1:0] fl_kind;
  logic [OffsetBits-1:0]           fl_start;
  logic [OffsetBits-1:0]           fl_len;

  // Token a comes from the pending token, token b from the byte itself.
  logic                            a_valid, b_valid;
  logic [stu_pkg::TokKindBits-1:0] a_kind, b_kind;
  logic [OffsetBits-1:0]           a_start, a_len, b_start, b_len;

  logic                        done;
  logic                        kw_start, kw_update;
  logic [stu_pkg::KwCount-1:0] kw_hits_in, kw_hits_out;
  logic [OffsetBits-1:0]       kw_idx;
  logic [TokW-1:0]             tok_a, tok_b;

  assign cur_len     = off_q - start_q;
  assign start_plus1 = start_q + OffsetBits'(1);

  assign kw_hits_in = kw_start ? '1 : hits_q;
  assign kw_idx     = kw_start ? '0 : cur_len;

  stu_kw_match #(
    .OffsetBits(OffsetBits)
  ) u_kw_match (
    .hits_in_i   (kw_hits_in),
    .match_idx_i (kw_idx),
    .char_i      (char_i),
    .hits_out_o  (kw_hits_out),
    .hits_q_i    (hits_q),
    .ident_len_i (cur_len),
    .ident_kind_o(ident_kind)
  );

  always_comb begin
    fl_valid = 1'b1;
    fl_kind  = stu_pkg::TokIdent;
    fl_start = start_q;
    fl_len   = cur_len;
    case (mode_q)
      stu_pkg::ModeIdent: fl_kind = ident_kind;
      stu_pkg::ModeNum:   fl_kind = stu_pkg::TokInt;
      stu_pkg::ModeStr: begin
        fl_kind  = stu_pkg::TokString;
        fl_start = start_plus1;
        fl_len   = '0;
      end
      stu_pkg::ModeEq: begin
        fl_kind = stu_pkg::TokAssign;
        fl_len  = OffsetBits'(1);
      end
      stu_pkg::ModeBang: begin
        fl_kind = stu_pkg::TokBang;
        fl_len  = OffsetBits'(1);
      end
      default: fl_valid = 1'b0;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    quote_d   = quote_q;
    off_d     = off_q;
    start_d   = start_q;
    line_d    = line_q;
    a_valid   = 1'b0;
    a_kind    = fl_kind;
    a_start   = fl_start;
    a_len     = fl_len;
    b_valid   = 1'b0;
    b_kind    = stu_pkg::TokEnd;
    b_start   = off_q;
    b_len     = '0;
    done      = 1'b0;
    kw_start  = 1'b0;
    kw_update = 1'b0;

    if (kind_i) begin
      // End of source: flush, then an end token; the offset does not move.
      a_valid = fl_valid;
      mode_d  = stu_pkg::ModeIdle;
      b_valid = 1'b1;
    end else begin
      case (mode_q)
        stu_pkg::ModeStr: begin
          done = 1'b1;
          if (char_i == quote_q) begin
            a_valid = 1'b1;
            a_kind  = stu_pkg::TokString;
            a_start = start_plus1;
            a_len   = cur_len - OffsetBits'(1);
            mode_d  = stu_pkg::ModeIdle;
          end else if (char_i == stu_pkg::ChNul) begin
            a_valid = 1'b1;
            mode_d  = stu_pkg::ModeIdle;
          end
        end
        stu_pkg::ModeIdent: begin
          if (stu_pkg::is_word(char_i)) begin
            kw_update = 1'b1;
            done      = 1'b1;
          end else begin
            a_valid = 1'b1;
            mode_d  = stu_pkg::ModeIdle;
          end
        end
        stu_pkg::ModeNum: begin
          if (stu_pkg::is_digit(char_i)) begin
            done = 1'b1;
          end else begin
            a_valid = 1'b1;
            mode_d  = stu_pkg::ModeIdle;
          end
        end
        stu_pkg::ModeEq, stu_pkg::ModeBang: begin
          a_valid = 1'b1;
          mode_d  = stu_pkg::ModeIdle;
          if (char_i == stu_pkg::ChEqual) begin
            a_kind  = (mode_q == stu_pkg::ModeEq) ? stu_pkg::TokEqEq : stu_pkg::TokNotEq;
            a_start = start_q;
            a_len   = OffsetBits'(2);
            done    = 1'b1;
          end
        end
        default: mode_d = stu_pkg::ModeIdle;
      endcase

      // When the pending token could not take the byte, the byte is scanned on its own.
      if (!done) begin
        if (char_i == stu_pkg::ChNewline) begin
          if (line_q != '1) begin
            line_d = line_q + LineBits'(1);
          end
        end else if (char_i inside {stu_pkg::ChCr, stu_pkg::ChSpace, stu_pkg::ChTab}) begin
          // Whitespace is skipped.
        end else if (stu_pkg::is_alpha(char_i)) begin
          mode_d   = stu_pkg::ModeIdent;
          start_d  = off_q;
          kw_start = 1'b1;
        end else if (stu_pkg::is_digit(char_i)) begin
          mode_d  = stu_pkg::ModeNum;
          start_d = off_q;
        end else if (char_i == stu_pkg::ChEqual) begin
          mode_d  = stu_pkg::ModeEq;
          start_d = off_q;
        end else if (char_i == stu_pkg::ChBang) begin
          mode_d  = stu_pkg::ModeBang;
          start_d = off_q;
        end else if (char_i inside {stu_pkg::ChDquote, stu_pkg::ChSquote}) begin
          mode_d  = stu_pkg::ModeStr;
          quote_d = char_i;
          start_d = off_q;
        end else if (char_i == stu_pkg::ChNul) begin
          b_valid = 1'b1;
        end else begin
          b_valid = 1'b1;
          b_kind  = stu_pkg::single_kind(char_i);
          b_len   = OffsetBits'(1);
        end
      end

      off_d = off_q + OffsetBits'(1);
    end
  end

  assign hits_d = (kw_start || kw_update) ? kw_hits_out : hits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stu_pkg::ModeIdle;
      quote_q <= '0;
      off_q   <= '0;
      start_q <= '0;
      line_q  <= LineBits'(1);
      hits_q  <= '1;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      off_q   <= off_d;
      start_q <= start_d;
      line_q  <= line_d;
      hits_q  <= hits_d;
    end
  end

  // Tokens carry the line before this byte; a newline that ends a pending token
  // only counts for the tokens after it.
  assign tok_a = {a_kind, line_q, a_start, a_len, !b_valid};
  assign tok_b = {b_kind, line_q, b_start, b_len, 1'b1};

  assign push_o.push0 = accept_i && (a_valid || b_valid);
  assign push_o.push1 = accept_i && a_valid && b_valid;
  assign tok0_o       = a_valid ? tok_a : tok_b;
  assign tok1_o       = tok_b;

endmodule

// ===== rtl/stu_tok_fifo.sv =====
// Token queue: takes up to two tokens per cycle, hands out one per transfer.
// Depends on stu_pkg.
module stu_tok_fifo #(
  parameter int DataWidth = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stu_pkg::tok_push_t push_i,
  input  logic [DataWidth-1:0] din0_i,
  input  logic [DataWidth-1:0] din1_i,
  output logic               room_lt2_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DataWidth-1:0] dout_o
);

  localparam int PtrW = stu_pkg::TokFifoPtrW;
  localparam int CntW = PtrW + 1;

  logic [DataWidth-1:0] mem_q [stu_pkg::TokFifoDepth];
  logic [PtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 pop;
  logic [PtrW-1:0]      wr_next;

  assign pop     = out_valid_o && !out_stall_i;
  assign wr_next = wr_q + PtrW'(1);

  assign wr_d  = wr_q + PtrW'(push_i.push0) + PtrW'(push_i.push1);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= din0_i;
    end
    if (push_i.push1) begin
      mem_q[wr_next] <= din1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign dout_o      = mem_q[rd_q];
  assign room_lt2_o  = (cnt_q > CntW'(stu_pkg::TokFifoDepth - 2));

endmodule
